/* design/histogram_contrast_stretch_core_assert.svh */
// Assertion macros shared by the contrast stretch modules.
`ifndef HISTOGRAM_CONTRAST_STRETCH_CORE_ASSERT_SVH
`define HISTOGRAM_CONTRAST_STRETCH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, off during reset.
`define HCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on clk, off during reset.
`define HCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HCS_ASSERT_IMP(lbl, ante, cons, msg)
`define HCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* design/hcs_pkg.sv */
// Shared types and constants of the histogram contrast stretch block.
`default_nettype none
package hcs_pkg;
	localparam int PIX_W   = 8;
	localparam int PIX_NUM = 256;
	localparam int NUM_W   = 16;
	localparam int STEP_W  = 4;
	localparam int Q_DEPTH = 4;
	localparam int QA_W    = 2;

	typedef logic [PIX_W-1:0] pix_t;

	localparam pix_t PIX_MAX = 8'd255;

	// Input word opcodes
	localparam logic OP_GATHER = 1'b0;
	localparam logic OP_APPLY  = 1'b1;

	// Job classes decided by the front end
	typedef logic [1:0] cls_t;
	localparam cls_t CLS_PASS = 2'd0;
	localparam cls_t CLS_ZERO = 2'd1;
	localparam cls_t CLS_FULL = 2'd2;
	localparam cls_t CLS_DIV  = 2'd3;
endpackage
`default_nettype wire

/* design/hcs_if.sv */
// Channel interfaces: pixel input, result output and the internal job queue.
`default_nettype none
interface hcs_in_if;
	import hcs_pkg::*;
	logic valid;
	logic ready;
	logic op;
	pix_t pixel;
	logic first;
	modport source (output valid, op, pixel, first, input ready);
	modport sink (input valid, op, pixel, first, output ready);
endinterface

interface hcs_out_if;
	import hcs_pkg::*;
	logic valid;
	logic ready;
	pix_t out_pixel;
	pix_t low_level;
	pix_t high_level;
	modport source (output valid, out_pixel, low_level, high_level, input ready);
	modport sink (input valid, out_pixel, low_level, high_level, output ready);
endinterface

interface hcs_job_if #(parameter int LW = 8);
	import hcs_pkg::*;
	logic valid;
	logic ready;
	cls_t kind;
	pix_t pix;
	logic [LW-1:0] den;
	pix_t lo8;
	pix_t hi8;
	modport source (output valid, kind, pix, den, lo8, hi8, input ready);
	modport sink (input valid, kind, pix, den, lo8, hi8, output ready);
endinterface
`default_nettype wire

/* design/hcs_front.sv */
// Front end: takes pixel words, tracks occupied bins, classifies apply words into jobs.
`default_nettype none
`include "histogram_contrast_stretch_core_assert.svh"
module hcs_front #(
	parameter int BINS   = 64,
	parameter int LEVELS = 256,
	parameter int BW     = 6,
	parameter int LW     = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	hcs_in_if.sink   pixels,
	hcs_job_if.source job
);
	import hcs_pkg::*;

	localparam int CW = (LW > PIX_W) ? LW : PIX_W;

	typedef logic [BW:0] bin_ent_t;
	typedef bin_ent_t bin_lut_t [PIX_NUM];
	typedef logic [LW-1:0] lvl_t;
	typedef lvl_t lvl_lut_t [BINS];

	// Pixel to {in range, bin}
	function automatic bin_lut_t build_bin_lut();
		bin_lut_t lut;
		for (int p = 0; p < PIX_NUM; p++) begin
			lut[p] = {(p < LEVELS), BW'(p * BINS / LEVELS)};
		end
		return lut;
	endfunction

	// Bin to level
	function automatic lvl_lut_t build_lvl_lut();
		lvl_lut_t lut;
		for (int b = 0; b < BINS; b++) begin
			lut[b] = LW'(b * LEVELS / BINS);
		end
		return lut;
	endfunction

	localparam bin_lut_t BIN_LUT = build_bin_lut();
	localparam lvl_lut_t LVL_LUT = build_lvl_lut();

	logic [BW-1:0] min_bin_q, max_bin_q;
	logic          any_seen_q;
	logic [BW-1:0] min_d, max_d;
	logic          seen_d;
	bin_ent_t      ent;
	logic          gather_acc;
	lvl_t          lo, hi;
	logic [CW-1:0] p_ext, lo_ext;

	assign gather_acc = pixels.valid && pixels.ready && (pixels.op == OP_GATHER);
	assign ent        = BIN_LUT[pixels.pixel];

	// Bin tracking for gather words
	always_comb begin
		min_d  = min_bin_q;
		max_d  = max_bin_q;
		seen_d = any_seen_q;
		if (gather_acc) begin
			if (pixels.first) begin
				min_d  = BW'(BINS - 1);
				max_d  = '0;
				seen_d = 1'b0;
			end
			if (ent[BW]) begin
				if (!seen_d) begin
					min_d  = ent[BW-1:0];
					max_d  = ent[BW-1:0];
					seen_d = 1'b1;
				end else begin
					if (ent[BW-1:0] < min_d) min_d = ent[BW-1:0];
					if (ent[BW-1:0] > max_d) max_d = ent[BW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bin_q  <= BW'(BINS - 1);
			max_bin_q  <= '0;
			any_seen_q <= 1'b0;
		end else begin
			min_bin_q  <= min_d;
			max_bin_q  <= max_d;
			any_seen_q <= seen_d;
		end
	end

	// Classify apply words
	assign lo     = LVL_LUT[min_bin_q];
	assign hi     = LVL_LUT[max_bin_q];
	assign p_ext  = CW'(pixels.pixel);
	assign lo_ext = CW'(lo);

	always_comb begin
		if (!any_seen_q)          job.kind = CLS_PASS;
		else if (p_ext <= lo_ext) job.kind = CLS_ZERO;
		else if (hi <= lo)        job.kind = CLS_FULL;
		else                      job.kind = CLS_DIV;
	end

	assign job.pix   = (job.kind == CLS_DIV) ? PIX_W'(p_ext - lo_ext) : pixels.pixel;
	assign job.den   = hi - lo;
	assign job.lo8   = PIX_W'(lo);
	assign job.hi8   = PIX_W'(hi);
	assign job.valid = pixels.valid && (pixels.op == OP_APPLY);
	assign pixels.ready = job.ready;

	`HCS_ASSERT_NXT(a_seen_after_gather, gather_acc && ent[BW], any_seen_q, "gather in range left no occupied bin")
	`HCS_ASSERT_IMP(a_bin_order, any_seen_q, min_bin_q <= max_bin_q, "lowest bin above highest bin")
endmodule
`default_nettype wire

/* design/hcs_queue.sv */
// Short job queue between front and back end.
`default_nettype none
module hcs_queue #(
	parameter int LW = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	hcs_job_if.sink   wr,
	hcs_job_if.source rd
);
	import hcs_pkg::*;

	localparam int EW = 2 + PIX_W + LW + PIX_W + PIX_W;

	logic [EW-1:0]  mem_q [Q_DEPTH];
	logic [QA_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QA_W:0]   cnt_q;
	logic           push, pop;
	logic [EW-1:0]  head;

	assign wr.ready = (cnt_q != (QA_W+1)'(Q_DEPTH));
	assign rd.valid = (cnt_q != '0);
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= {wr.kind, wr.pix, wr.den, wr.lo8, wr.hi8};
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign {rd.kind, rd.pix, rd.den, rd.lo8, rd.hi8} = head;
endmodule
`default_nettype wire

/* design/hcs_back.sv */
// Back end: bit-serial divide with round-to-even and the output register.
`default_nettype none
`include "histogram_contrast_stretch_core_assert.svh"
module hcs_back #(
	parameter int LW = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	hcs_job_if.sink    job,
	hcs_out_if.source  results
);
	import hcs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [NUM_W-1:0]  nq_q;
	logic [LW-1:0]     rem_q, den_q;
	logic [STEP_W-1:0] step_q;
	pix_t              lo8_q, hi8_q;
	pix_t              out_pix_q, out_lo_q, out_hi_q;
	logic              out_valid_q;

	logic              slot_free, pop;
	logic [LW:0]       trial, diff, den_ext, twice_rem;
	logic              ge, inc;
	logic [NUM_W:0]    q_r;
	pix_t              q_sat;

	assign slot_free = !out_valid_q || results.ready;
	assign job.ready = (state_q == S_IDLE) && slot_free;
	assign pop       = job.valid && job.ready;

	// One quotient bit per step
	assign den_ext = {1'b0, den_q};
	assign trial   = {rem_q, nq_q[NUM_W-1]};
	assign diff    = trial - den_ext;
	assign ge      = (trial >= den_ext);

	// Round to nearest, ties to even, then saturate
	assign twice_rem = {rem_q, 1'b0};
	assign inc   = (twice_rem > den_ext) || ((twice_rem == den_ext) && nq_q[0]);
	assign q_r   = {1'b0, nq_q} + (NUM_W+1)'(inc);
	assign q_sat = (q_r > (NUM_W+1)'(PIX_MAX)) ? PIX_MAX : q_r[PIX_W-1:0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop && job.kind == CLS_DIV) begin
						state_q <= S_DIV;
						step_q  <= '0;
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(NUM_W - 1)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pop) begin
			nq_q  <= NUM_W'(job.pix) * NUM_W'(PIX_MAX);
			rem_q <= '0;
			den_q <= job.den;
			lo8_q <= job.lo8;
			hi8_q <= job.hi8;
		end else if (state_q == S_DIV) begin
			nq_q  <= {nq_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[LW-1:0] : trial[LW-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((pop && job.kind != CLS_DIV) || (state_q == S_DONE && slot_free)) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && job.kind != CLS_DIV) begin
			case (job.kind)
				CLS_PASS: out_pix_q <= job.pix;
				CLS_ZERO: out_pix_q <= '0;
				CLS_FULL: out_pix_q <= PIX_MAX;
				default:  out_pix_q <= job.pix;
			endcase
			out_lo_q <= (job.kind == CLS_PASS) ? '0 : job.lo8;
			out_hi_q <= (job.kind == CLS_PASS) ? '0 : job.hi8;
		end else if (state_q == S_DONE && slot_free) begin
			out_pix_q <= q_sat;
			out_lo_q  <= lo8_q;
			out_hi_q  <= hi8_q;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.out_pixel  = out_pix_q;
	assign results.low_level  = out_lo_q;
	assign results.high_level = out_hi_q;

	`HCS_ASSERT_IMP(a_no_pop_busy, state_q == S_DIV, !job.ready, "job taken while dividing")
	`HCS_ASSERT_IMP(a_rem_bound, state_q == S_DIV, rem_q < den_q, "partial remainder not below divisor")
	`HCS_ASSERT_NXT(a_done_emits, state_q == S_DONE && slot_free, results.valid && state_q == S_IDLE, "finished quotient not presented")
endmodule
`default_nettype wire

/* design/histogram_contrast_stretch_core.sv */
// Top level of the min-max histogram contrast stretch block.
// Use: words enter on the pixels channel (op, pixel, first) and leave on the results
// channel (out_pixel, low_level, high_level); both are valid/ready, a word moves at a
// clock edge where both are high. A gather word (op 0) updates the lowest and highest
// occupied histogram bin and produces nothing; first on it clears the tracking before it.
// An apply word (op 1) produces one result word stretched between the two bin levels.
// The front end updates bins and classifies apply words in the cycle they are taken, and
// queues them (four deep). Gather words are taken whenever pixels.ready is high.
// An apply word needs no division when nothing was gathered, the pixel is at or below
// the low level, or the levels are equal; otherwise its result comes from the bit-serial
// divider in the back end, which makes one quotient bit per cycle over 16 bits and takes
// no new word while it divides. Other words follow at one per cycle while no division
// runs and the receiver takes results.
// Reset (arst_n low) clears the bin tracking to "nothing gathered", empties the queue
// and drops any pending result.
// When the receiver stalls the result waits in the output register and the back end
// takes no new word; the queue then fills and pixels.ready falls.
`default_nettype none
module histogram_contrast_stretch_core #(
	parameter int BINS   = 64,
	parameter int LEVELS = 256
) (
	input wire logic  clk,
	input wire logic  arst_n,
	hcs_in_if.sink    pixels,
	hcs_out_if.source results
);
	import hcs_pkg::*;

	localparam int BW = $clog2(BINS);
	localparam int LW = $clog2(LEVELS);

	hcs_job_if #(.LW(LW)) fr_job ();
	hcs_job_if #(.LW(LW)) bk_job ();

	hcs_front #(
		.BINS   (BINS),
		.LEVELS (LEVELS),
		.BW     (BW),
		.LW     (LW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.job    (fr_job)
	);

	hcs_queue #(
		.LW (LW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fr_job),
		.rd     (bk_job)
	);

	hcs_back #(
		.LW (LW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (bk_job),
		.results (results)
	);
endmodule
`default_nettype wire
